// ----- design/pcap_pkg.sv -----
// ----------------------------------------------------------------------------
// pcap_pkg: shared types and constants for the capture header extractor
// Item structs, phase enum and the front-to-back command struct.
// ----------------------------------------------------------------------------
`default_nettype none
package pcap_pkg;

   localparam int GlobalLen   = 24;
   localparam int RecordLen   = 16;
   localparam int EthAlen     = 6;
   localparam int PayloadKeep = 34;
   localparam logic [15:0] Ipv4Kind = 16'h0800;
   localparam logic [31:0] MagicLe = 32'hd4c3b2a1;  // first byte in msb
   localparam logic [31:0] MagicBe = 32'ha1b2c3d4;
   localparam int QueueDepth = 2;

   typedef enum logic [1:0] {
      PH_GLOBAL  = 2'd0,
      PH_RECORD  = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_SKIP    = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [31:0] ts_seconds;
      logic [31:0] ts_micros;
      logic [31:0] captured_length;
      logic [31:0] original_length;
      logic [47:0] dest_mac;
      logic [47:0] source_mac;
      logic [15:0] ether_kind;
      logic [31:0] ip_source;
      logic [31:0] ip_dest;
      logic [7:0]  ip_proto;
   } rsp_type;

   // classified byte handed from front to back
   typedef struct packed {
      logic       rec_clear;   // first record-header byte: clear accumulators
      logic       rec_take;    // record-header byte
      logic [3:0] rec_pos;
      logic       pay_take;    // kept payload byte
      logic [5:0] pay_pos;
      logic       little;
      logic       emit_rec;
      logic       emit_bad;
      logic [7:0] data;
   } cmd_type;

endpackage
`default_nettype wire

// ----- design/pcap_front.sv -----
// ----------------------------------------------------------------------------
// pcap_front: byte classifier
// Tracks file phase, checks magic, counts payload and issues commands.
// ----------------------------------------------------------------------------
`default_nettype none
module pcap_front
   import pcap_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         cmd_valid,
   input  wire logic    cmd_stall,
   output cmd_type      cmd_data
);

   phase_type   phase_ff, phase_in;
   logic [4:0]  hpos_ff, hpos_in;
   logic        little_ff, little_in;
   logic [31:0] left_ff, left_in;
   logic [5:0]  ppos_ff, ppos_in;
   logic [31:0] caplen_ff, caplen_in;   // captured length as it builds up
   logic        take;
   logic [7:0]  b;
   logic [1:0]  mk;
   logic [31:0] cap_next;

   assign req_stall = cmd_stall;
   assign take      = req_valid && !cmd_stall;
   assign b         = req_data.data_byte;
   assign mk        = hpos_ff[1:0];

   always_comb begin
      cap_next = little_ff ? (caplen_ff | ({24'd0, b} << {hpos_ff[1:0], 3'd0}))
                           : {caplen_ff[23:0], b};
   end

   // next state
   always_comb begin
      phase_in  = phase_ff;
      hpos_in   = hpos_ff;
      little_in = little_ff;
      left_in   = left_ff;
      ppos_in   = ppos_ff;
      caplen_in = caplen_ff;
      case (phase_ff)
         PH_GLOBAL: begin
            if (hpos_ff == 5'd0) begin
               if (b == MagicLe[31:24]) little_in = 1'b1;
               else if (b == MagicBe[31:24]) little_in = 1'b0;
               else phase_in = PH_SKIP;
            end else if (hpos_ff < 5'd4) begin
               if (b != (little_ff ? MagicLe[31 - {mk, 3'd0} -: 8]
                                   : MagicBe[31 - {mk, 3'd0} -: 8]))
                  phase_in = PH_SKIP;
            end
            if (phase_in == PH_GLOBAL) begin
               if (hpos_ff == 5'(GlobalLen - 1)) begin
                  phase_in = PH_RECORD;
                  hpos_in  = 5'd0;
               end else begin
                  hpos_in = hpos_ff + 5'd1;
               end
            end
         end
         PH_RECORD: begin
            if (hpos_ff[3:2] == 2'd2) caplen_in = cap_next;
            if (hpos_ff[3:0] == 4'(RecordLen - 1)) begin
               hpos_in = 5'd0;
               ppos_in = 6'd0;
               left_in = caplen_ff;
               if (caplen_ff != 32'd0) phase_in = PH_PAYLOAD;
            end else begin
               hpos_in = {1'b0, hpos_ff[3:0] + 4'd1};
            end
         end
         PH_PAYLOAD: begin
            if (ppos_ff < 6'(PayloadKeep)) ppos_in = ppos_ff + 6'd1;
            left_in = left_ff - 32'd1;
            if (left_ff == 32'd1) begin
               phase_in = PH_RECORD;
               hpos_in  = 5'd0;
            end
         end
         default: ;
      endcase
      if (hpos_ff[3:0] == 4'd0 && phase_ff == PH_RECORD) caplen_in = 32'd0;
      if (req_data.end_of_file) begin
         phase_in  = PH_GLOBAL;
         hpos_in   = 5'd0;
         little_in = 1'b0;
         left_in   = 32'd0;
         ppos_in   = 6'd0;
         caplen_in = 32'd0;
      end
   end

   // outputs
   always_comb begin
      cmd_data           = '0;
      cmd_data.data      = b;
      cmd_data.little    = little_ff;
      cmd_data.rec_pos   = hpos_ff[3:0];
      cmd_data.pay_pos   = ppos_ff;
      cmd_data.rec_take  = (phase_ff == PH_RECORD);
      cmd_data.rec_clear = (phase_ff == PH_RECORD) && (hpos_ff[3:0] == 4'd0);
      cmd_data.pay_take  = (phase_ff == PH_PAYLOAD) && (ppos_ff < 6'(PayloadKeep));
      case (phase_ff)
         PH_GLOBAL: begin
            cmd_data.emit_bad = (phase_in == PH_SKIP && !req_data.end_of_file)
                             || (req_data.end_of_file && !(hpos_ff == 5'(GlobalLen - 1)
                                 && !(hpos_ff < 5'd4)))
                             || (req_data.end_of_file && hpos_ff == 5'd0);
         end
         // last header byte: empty payload, or header complete at end of file
         PH_RECORD: cmd_data.emit_rec = (hpos_ff[3:0] == 4'(RecordLen - 1))
                                     && ((caplen_ff == 32'd0) || req_data.end_of_file);
         PH_PAYLOAD: cmd_data.emit_rec = (left_ff == 32'd1) || req_data.end_of_file;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_GLOBAL;
         hpos_ff   <= '0;
         little_ff <= 1'b0;
         left_ff   <= '0;
         ppos_ff   <= '0;
         caplen_ff <= '0;
      end else if (take) begin
         phase_ff  <= phase_in;
         hpos_ff   <= hpos_in;
         little_ff <= little_in;
         left_ff   <= left_in;
         ppos_ff   <= ppos_in;
         caplen_ff <= caplen_in;
      end
   end

   assign cmd_valid = req_valid;

endmodule
`default_nettype wire

// ----- design/pcap_queue.sv -----
// ----------------------------------------------------------------------------
// pcap_queue: two-entry command queue
// Decouples the classifier from the field assembler.
// ----------------------------------------------------------------------------
`default_nettype none
module pcap_queue
   import pcap_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_stall,
   input  wire cmd_type in_data,
   output logic         out_valid,
   input  wire logic    out_stall,
   output cmd_type      out_data
);

   cmd_type    mem_ff [QueueDepth];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_stall  = (cnt_ff == 2'(QueueDepth));
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rd_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule
`default_nettype wire

// ----- design/pcap_back.sv -----
// ----------------------------------------------------------------------------
// pcap_back: field assembler
// Builds record and frame fields and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none
module pcap_back
   import pcap_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   output logic         cmd_stall,
   input  wire cmd_type cmd_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic [31:0] word_ff [4];
   logic [31:0] word_in [4];
   logic [47:0] dmac_ff, dmac_in, smac_ff, smac_in;
   logic [15:0] kind_ff, kind_in;
   logic [31:0] ips_ff, ips_in, ipd_ff, ipd_in;
   logic [7:0]  prot_ff, prot_in;
   logic        valid_ff;
   rsp_type     out_ff, out_in;
   logic        take;
   logic [1:0]  f, k;
   logic [5:0]  q;
   logic        ip;

   assign cmd_stall = valid_ff && rsp_stall;
   assign take      = cmd_valid && !cmd_stall;
   assign rsp_valid = valid_ff;
   assign rsp_data  = out_ff;
   assign f = cmd_data.rec_pos[3:2];
   assign k = cmd_data.rec_pos[1:0];
   assign q = cmd_data.pay_pos;

   always_comb begin
      for (int i = 0; i < 4; i++) word_in[i] = cmd_data.rec_clear ? 32'd0 : word_ff[i];
      dmac_in = cmd_data.rec_clear ? 48'd0 : dmac_ff;
      smac_in = cmd_data.rec_clear ? 48'd0 : smac_ff;
      kind_in = cmd_data.rec_clear ? 16'd0 : kind_ff;
      ips_in  = cmd_data.rec_clear ? 32'd0 : ips_ff;
      ipd_in  = cmd_data.rec_clear ? 32'd0 : ipd_ff;
      prot_in = cmd_data.rec_clear ? 8'd0  : prot_ff;
      if (cmd_data.rec_take) begin
         if (cmd_data.little)
            word_in[f] = word_in[f] | ({24'd0, cmd_data.data} << {k, 3'd0});
         else
            word_in[f] = {word_in[f][23:0], cmd_data.data};
      end
      if (cmd_data.pay_take) begin
         if (q < 6'(EthAlen))
            dmac_in[8*(5 - q[2:0]) +: 8] = cmd_data.data;
         else if (q < 6'(2 * EthAlen))
            smac_in[8*(11 - q[3:0]) +: 8] = cmd_data.data;
         else if (q < 6'd14)
            kind_in[8*(13 - q[3:0]) +: 8] = cmd_data.data;
         else if (q == 6'd23)
            prot_in = cmd_data.data;
         else if (q >= 6'd26 && q < 6'd30)
            ips_in[8*(29 - q) +: 8] = cmd_data.data;
         else if (q >= 6'd30 && q < 6'd34)
            ipd_in[8*(33 - q) +: 8] = cmd_data.data;
      end
      ip     = (kind_in == Ipv4Kind);
      out_in = '0;
      if (cmd_data.emit_bad) begin
         out_in.status = 1'b1;
      end else begin
         out_in.ts_seconds      = word_in[0];
         out_in.ts_micros       = word_in[1];
         out_in.captured_length = word_in[2];
         out_in.original_length = word_in[3];
         out_in.dest_mac        = dmac_in;
         out_in.source_mac      = smac_in;
         out_in.ether_kind      = kind_in;
         out_in.ip_source       = ip ? ips_in : 32'd0;
         out_in.ip_dest         = ip ? ipd_in : 32'd0;
         out_in.ip_proto        = ip ? prot_in : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         for (int i = 0; i < 4; i++) word_ff[i] <= word_in[i];
         dmac_ff <= dmac_in;
         smac_ff <= smac_in;
         kind_ff <= kind_in;
         ips_ff  <= ips_in;
         ipd_ff  <= ipd_in;
         prot_ff <= prot_in;
         if (cmd_data.emit_bad || cmd_data.emit_rec) out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= cmd_data.emit_bad || cmd_data.emit_rec;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

endmodule
`default_nettype wire

// ----- design/pcap_stream_header_extractor.sv -----
// ----------------------------------------------------------------------------
// pcap_stream_header_extractor: capture-file record header parser
// Checks the magic, walks record headers and reports one summary per record.
// ----------------------------------------------------------------------------
// Takes one file byte per transfer, at one byte per clock unless stalled. A
// classifier tracks the global header, record header and payload phases and
// hands tagged bytes through a two-entry queue to the field assembler, whose
// output register holds the summary; rsp_valid rises once the completing byte
// has passed the queue and the summary is registered. A stall on rsp fills the
// queue and then stalls req.
`default_nettype none
module pcap_stream_header_extractor
   import pcap_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    f_valid, f_stall, b_valid, b_stall;
   cmd_type f_data, b_data;

   pcap_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .cmd_valid(f_valid), .cmd_stall(f_stall), .cmd_data(f_data)
   );

   pcap_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_stall(f_stall), .in_data(f_data),
      .out_valid(b_valid), .out_stall(b_stall), .out_data(b_data)
   );

   pcap_back u_back (
      .clock, .reset,
      .cmd_valid(b_valid), .cmd_stall(b_stall), .cmd_data(b_data),
      .rsp_valid, .rsp_stall, .rsp_data
   );

endmodule
`default_nettype wire
